// ===== sv/wsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfd_pkg
// shared types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
package wsfd_pkg;

    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_EXT,
        PH_MASK,
        PH_DATA
    } t_phase;

    localparam logic [1:0] KIND_HEADER    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
    localparam logic [1:0] KIND_BAD_CONT  = 2'd2;
    localparam logic [1:0] KIND_TOO_LARGE = 2'd3;

    localparam logic [3:0] OPC_CONT  = 4'd0;
    localparam logic [3:0] OPC_CLOSE = 4'd8;
    localparam logic [3:0] OPC_PING  = 4'd9;
    localparam logic [3:0] OPC_PONG  = 4'd10;

    localparam logic [6:0]  LEN16_CODE = 7'd126;
    localparam logic [6:0]  LEN64_CODE = 7'd127;
    localparam logic [3:0]  EXT16_BYTES = 4'd2;
    localparam logic [3:0]  EXT64_BYTES = 4'd8;
    localparam logic [3:0]  MASK_BYTES  = 4'd4;
    localparam logic [31:0] LEN_LIMIT   = 32'h8000_0000;

    localparam int TDATA_W = 48;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [3:0]  opcode;
        logic        final_flag;
        logic        masked_flag;
        logic [31:0] payload_length;
        logic [7:0]  data;
        logic        frame_end;
    } t_result;

    typedef struct packed {
        logic halted;
    } t_status;

endpackage

// ===== sv/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// parses a websocket byte stream into header items and unmasked payload items
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries the received stream, one byte per item in tdata.
//   m_axis gives one item per frame header (tuser kind 0, or 2 for a
//   continuation with no open message) and one per payload byte (kind 1).
//   tlast marks the last item of a frame. an extended length above 2^31
//   gives a kind 3 item, after which every byte is swallowed until reset.
//   a result appears on m_axis in the cycle after the byte that
//   completes it is taken. throughput: one byte per cycle while m_axis is
//   ready, set by the single parser step from state to output register.
//   header bytes and dropped payload bytes produce no item.
//   reset clears the parser state and empties the output register.
//   when m_axis stalls with an item held, s_axis_tready drops until the
//   held item is taken; the byte is then taken in the same cycle.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
    import wsfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // stream_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // opcode[3:0], final_flag[4], masked_flag[5], payload_length[37:6],
    // data[45:38], zero fill[47:46]
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]         m_axis_tuser,   // kind[1:0]
    output logic               m_axis_tlast    // frame_end
);

    logic               accept;
    t_result            result;
    t_status            status;

    logic               r_valid;
    logic [TDATA_W-1:0] r_tdata;
    logic [1:0]         r_tuser;
    logic               r_tlast;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    wsfd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .o_result (result),
        .o_status (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && result.valid) begin
            r_tdata <= {2'b00, result.data, result.payload_length,
                        result.masked_flag, result.final_flag, result.opcode};
            r_tuser <= result.kind;
            r_tlast <= result.frame_end;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tuser  = r_tuser;
    assign m_axis_tlast  = r_tlast;

    // once halted the parser stays halted
    a_halt_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.halted |=> status.halted)
        else $error("halt flag cleared without reset");

    // a halted parser never loads a new item
    a_halt_silent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.halted && s_axis_tready) |=> !m_axis_tvalid)
        else $error("item produced while halted");

    // a length error item is always accompanied by the halt
    a_too_large_halts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_TOO_LARGE)) |-> status.halted)
        else $error("length error without halt");

    // only payload items carry data
    a_data_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != KIND_PAYLOAD)) |-> (m_axis_tdata[45:38] == 8'd0))
        else $error("non-payload item carries data");

endmodule

// ===== sv/wsfd_parser.sv =====
// ----------------------------------------------------------------------------
// wsfd_parser
// header parser, length decode and payload unmasking, one byte per step
// ----------------------------------------------------------------------------
module wsfd_parser
    import wsfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output t_result    o_result,
    output t_status    o_status
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_cnt, n_cnt;
    logic [31:0] r_len_lo, n_len_lo;
    logic        r_len_hinz, n_len_hinz;
    logic [31:0] r_key, n_key;
    logic [31:0] r_left, n_left;
    logic [1:0]  r_idx, n_idx;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_final, n_final;
    logic        r_masked, n_masked;
    logic        r_drop, n_drop;
    logic        r_msg_open, n_msg_open;
    logic        r_halted, n_halted;

    logic        step;
    logic [6:0]  len7;
    logic        hdr2_ext;
    logic [31:0] ext_lo;
    logic        ext_hinz;
    logic [3:0]  cnt_dec;
    logic        ext_last;
    logic        too_big;
    logic        len_done;
    logic [31:0] len_val;
    logic        masked_now;
    logic        hdr_done;
    logic [31:0] hdr_len;
    logic [31:0] left_dec;
    logic [7:0]  mask_byte;
    logic        bad_cont;
    logic        is_control;

    assign step     = i_accept && !r_halted;
    assign len7     = i_byte[6:0];
    assign hdr2_ext = (len7 == LEN16_CODE) || (len7 == LEN64_CODE);
    // extended length kept as low word plus a sticky flag for the high word
    assign ext_lo   = {r_len_lo[23:0], i_byte};
    assign ext_hinz = r_len_hinz || (r_len_lo[31:24] != 8'd0);
    assign cnt_dec  = r_cnt - 4'd1;
    assign ext_last = (cnt_dec == 4'd0);
    assign too_big  = ext_hinz || (ext_lo > LEN_LIMIT);

    assign len_done = ((r_phase == PH_HDR2) && !hdr2_ext) ||
                      ((r_phase == PH_EXT) && ext_last && !too_big);
    assign len_val    = (r_phase == PH_HDR2) ? {25'd0, len7} : ext_lo;
    assign masked_now = (r_phase == PH_HDR2) ? i_byte[7] : r_masked;
    assign hdr_done   = (len_done && !masked_now) ||
                        ((r_phase == PH_MASK) && ext_last);
    assign hdr_len    = (r_phase == PH_MASK) ? r_len_lo : len_val;
    assign left_dec   = r_left - 32'd1;

    assign bad_cont   = (r_opcode == OPC_CONT) && !r_msg_open;
    assign is_control = (r_opcode == OPC_CLOSE) || (r_opcode == OPC_PING) ||
                        (r_opcode == OPC_PONG);

    always_comb begin
        case (r_idx)
            2'd0:    mask_byte = r_key[31:24];
            2'd1:    mask_byte = r_key[23:16];
            2'd2:    mask_byte = r_key[15:8];
            default: mask_byte = r_key[7:0];
        endcase
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (step) begin
            unique case (r_phase) inside
                PH_HDR1: n_phase = PH_HDR2;
                PH_HDR2, PH_EXT, PH_MASK: begin
                    if ((r_phase == PH_EXT) && ext_last && too_big) begin
                        n_phase = PH_HDR1;
                    end else if ((r_phase == PH_HDR2) && hdr2_ext) begin
                        n_phase = PH_EXT;
                    end else if (len_done && masked_now) begin
                        n_phase = PH_MASK;
                    end else if (hdr_done) begin
                        n_phase = (hdr_len == 32'd0) ? PH_HDR1 : PH_DATA;
                    end
                end
                PH_DATA: n_phase = (left_dec == 32'd0) ? PH_HDR1 : PH_DATA;
                default: n_phase = PH_HDR1;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_cnt      = r_cnt;
        n_len_lo   = r_len_lo;
        n_len_hinz = r_len_hinz;
        n_key      = r_key;
        n_left     = r_left;
        n_idx      = r_idx;
        n_opcode   = r_opcode;
        n_final    = r_final;
        n_masked   = r_masked;
        n_drop     = r_drop;
        n_msg_open = r_msg_open;
        n_halted   = r_halted;
        o_result   = '0;

        if (step) begin
            unique case (r_phase)
                PH_HDR1: begin
                    n_final  = i_byte[7];
                    n_opcode = i_byte[3:0];
                end
                PH_HDR2: begin
                    n_masked   = i_byte[7];
                    n_key      = 32'd0;
                    n_len_hinz = 1'b0;
                    n_len_lo   = hdr2_ext ? 32'd0 : {25'd0, len7};
                    if (hdr2_ext) begin
                        n_cnt = (len7 == LEN16_CODE) ? EXT16_BYTES : EXT64_BYTES;
                    end else if (i_byte[7]) begin
                        n_cnt = MASK_BYTES;
                    end
                end
                PH_EXT: begin
                    n_len_lo   = ext_lo;
                    n_len_hinz = ext_hinz;
                    n_cnt      = cnt_dec;
                    if (ext_last && too_big) begin
                        n_halted          = 1'b1;
                        o_result.valid    = 1'b1;
                        o_result.kind     = KIND_TOO_LARGE;
                    end else if (ext_last && r_masked) begin
                        n_cnt = MASK_BYTES;
                    end
                end
                PH_MASK: begin
                    n_key = {r_key[23:0], i_byte};
                    n_cnt = cnt_dec;
                end
                PH_DATA: begin
                    n_idx  = r_idx + 2'd1;
                    n_left = left_dec;
                    if (r_drop) begin
                        if (left_dec == 32'd0) begin
                            n_drop = 1'b0;
                        end
                    end else begin
                        o_result.valid          = 1'b1;
                        o_result.kind           = KIND_PAYLOAD;
                        o_result.payload_length = r_len_lo;
                        o_result.data           = i_byte ^ mask_byte;
                        o_result.frame_end      = (left_dec == 32'd0);
                    end
                end
                default: ;
            endcase

            if (hdr_done) begin
                if (!bad_cont && !is_control) begin
                    n_msg_open = !r_final;
                end
                n_drop                  = bad_cont && (hdr_len != 32'd0);
                n_left                  = hdr_len;
                n_idx                   = 2'd0;
                o_result.valid          = 1'b1;
                o_result.kind           = bad_cont ? KIND_BAD_CONT : KIND_HEADER;
                o_result.payload_length = hdr_len;
                o_result.frame_end      = bad_cont || (hdr_len == 32'd0);
            end
        end

        o_result.opcode      = r_opcode;
        o_result.final_flag  = r_final;
        o_result.masked_flag = n_masked;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR1;
            r_cnt      <= 4'd0;
            r_len_lo   <= 32'd0;
            r_len_hinz <= 1'b0;
            r_key      <= 32'd0;
            r_left     <= 32'd0;
            r_idx      <= 2'd0;
            r_opcode   <= 4'd0;
            r_final    <= 1'b0;
            r_masked   <= 1'b0;
            r_drop     <= 1'b0;
            r_msg_open <= 1'b0;
            r_halted   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_len_lo   <= n_len_lo;
            r_len_hinz <= n_len_hinz;
            r_key      <= n_key;
            r_left     <= n_left;
            r_idx      <= n_idx;
            r_opcode   <= n_opcode;
            r_final    <= n_final;
            r_masked   <= n_masked;
            r_drop     <= n_drop;
            r_msg_open <= n_msg_open;
            r_halted   <= n_halted;
        end
    end

    assign o_status.halted = r_halted;

endmodule
